>>> rtl/rfc_pkg.sv
// shared types and constants for the rail fence cipher block
`timescale 1ns / 1ps

package rfc_pkg;

  localparam int MAX_LEN   = 64;
  localparam int MAX_RAILS = 16;
  localparam int ADDR_W    = $clog2(MAX_LEN);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int RAILS_W   = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 5;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_RAILS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 1'd1;

  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_out;
    logic       overflow;
  } out_beat_t;

  // classified input beat handed from the front to the back
  typedef struct packed {
    logic [7:0]        data;
    logic [ADDR_W-1:0] addr;
    logic              keep;
    logic              eom;
    logic [CNT_W-1:0]  len;
    logic              ovf;
  } cmd_t;

endpackage

>>> rtl/rail_fence_cipher_top.sv
// rail fence cipher: buffers a message, then emits its zigzag transposition
// load: one byte per cycle while the queue has room, into the message store via a four-beat queue
// emit: after the end-of-message beat is taken, each result takes a store read, then an
// output register load, and is held while out_stall is high; decrypt first adds a dealing
// pass per byte (store read, then write into the plain buffer) before emission
// reset clears counters, queue, control and config (3 rails, encrypt); store is not cleared
`timescale 1ns / 1ps

module rail_fence_cipher_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  rfc_pkg::in_beat_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output rfc_pkg::out_beat_t                 out_data,
  input  logic                               cfg_write,
  input  logic [rfc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rfc_pkg::CFG_W-1:0]          cfg_data
);

  logic [rfc_pkg::RAILS_W-1:0] rails;
  logic                        mode;
  logic                        q_full;
  logic                        q_push;
  logic                        q_pop;
  logic                        q_not_empty;
  rfc_pkg::cmd_t               q_cmd;
  rfc_pkg::cmd_t               q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      rails <= rfc_pkg::RAILS_W'(3);
      mode  <= rfc_pkg::MODE_ENCRYPT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rfc_pkg::REG_RAILS: rails <= cfg_data;
        rfc_pkg::REG_MODE:  mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  rfc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  rfc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  rfc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .rails       (rails),
    .mode        (mode),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

>>> rtl/rfc_front.sv
// front end: takes input beats, assigns store addresses and tracks overflow
`timescale 1ns / 1ps

module rfc_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  rfc_pkg::in_beat_t in_data,
  input  logic             q_full,
  output logic             q_push,
  output rfc_pkg::cmd_t    q_cmd
);

  logic [rfc_pkg::CNT_W-1:0] count;
  logic [rfc_pkg::CNT_W-1:0] count_next;
  logic                      ovf;
  logic                      ovf_next;
  logic                      keep;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign keep     = count < rfc_pkg::CNT_W'(rfc_pkg::MAX_LEN);

  always_comb begin
    count_next     = keep ? count + 1'b1 : count;
    ovf_next       = ovf || !keep;
    q_cmd.data     = in_data.data_byte;
    q_cmd.addr     = count[rfc_pkg::ADDR_W-1:0];
    q_cmd.keep     = keep;
    q_cmd.eom      = in_data.end_of_message;
    q_cmd.len      = count_next;
    q_cmd.ovf      = ovf_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (q_push) begin
      if (in_data.end_of_message) begin
        count <= '0;
        ovf   <= 1'b0;
      end else begin
        count <= count_next;
        ovf   <= ovf_next;
      end
    end
  end

endmodule

>>> rtl/rfc_queue.sv
// short queue of classified beats between front and back
`timescale 1ns / 1ps

module rfc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rfc_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output rfc_pkg::cmd_t head
);

  rfc_pkg::cmd_t                entries [rfc_pkg::Q_DEPTH];
  logic [rfc_pkg::Q_PTR_W-1:0] wr_ptr;
  logic [rfc_pkg::Q_PTR_W-1:0] rd_ptr;
  logic [rfc_pkg::Q_PTR_W:0]   fill;
  logic                        do_pop;

  assign full      = fill == (rfc_pkg::Q_PTR_W+1)'(rfc_pkg::Q_DEPTH);
  assign not_empty = fill != '0;
  assign head      = entries[rd_ptr];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (!push && do_pop) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

>>> rtl/rfc_back.sv
// back end: message store, zigzag walk and result emission
`timescale 1ns / 1ps

module rfc_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_not_empty,
  input  rfc_pkg::cmd_t               q_head,
  output logic                        q_pop,
  input  logic [rfc_pkg::RAILS_W-1:0] rails,
  input  logic                        mode,
  output logic                        out_valid,
  input  logic                        out_stall,
  output rfc_pkg::out_beat_t          out_data
);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_DRD  = 3'd1;
  localparam logic [2:0] S_DWR  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  localparam int CW = rfc_pkg::CNT_W;
  localparam int RW = rfc_pkg::RAILS_W;
  localparam int AW = rfc_pkg::ADDR_W;

  logic [7:0]    store [rfc_pkg::MAX_LEN];
  logic [7:0]    plain [rfc_pkg::MAX_LEN];
  logic [7:0]    st_q;
  logic [7:0]    pl_q;
  logic [AW-1:0] st_addr;

  logic [2:0]    state;
  logic [CW-1:0] len;
  logic          ovf;
  logic [RW-1:0] nr;
  logic          dec;
  logic [RW-1:0] rail;
  logic [CW-1:0] pos;
  logic          ph;
  logic [CW-1:0] k;

  logic [RW-1:0] nr_sat;
  logic [CW-1:0] period;
  logic [CW-1:0] step;
  logic [CW-1:0] sum;
  logic [RW-1:0] rail_next;
  logic [CW-1:0] pos_next;
  logic          ph_next;
  logic          last_k;
  logic          out_free;

  // zero rails acts as one, large counts saturate
  always_comb begin
    if (rails == '0) begin
      nr_sat = RW'(1);
    end else if (rails > RW'(rfc_pkg::MAX_RAILS)) begin
      nr_sat = RW'(rfc_pkg::MAX_RAILS);
    end else begin
      nr_sat = rails;
    end
  end

  // next zigzag position: a single rail steps by one, edge rails step a full period, middle rails alternate
  always_comb begin
    period = {CW'(nr - 1'b1)} << 1;
    if (nr == RW'(1)) begin
      step = CW'(1);
    end else if (rail == '0 || rail == nr - 1'b1) begin
      step = period;
    end else if (ph) begin
      step = CW'({rail, 1'b0});
    end else begin
      step = period - CW'({rail, 1'b0});
    end
    sum = pos + step;
    if (sum >= len) begin
      rail_next = rail + 1'b1;
      pos_next  = CW'(rail + 1'b1);
      ph_next   = 1'b0;
    end else begin
      rail_next = rail;
      pos_next  = sum;
      ph_next   = !ph;
    end
  end

  assign last_k   = k == len - 1'b1;
  assign out_free = !out_valid || !out_stall;
  assign q_pop    = (state == S_LOAD) && q_not_empty;
  assign st_addr  = (state == S_DRD) ? k[AW-1:0] : pos[AW-1:0];

  always_ff @(posedge clk) begin
    if (q_pop && q_head.keep) begin
      store[q_head.addr] <= q_head.data;
    end
    st_q <= store[st_addr];
    if (state == S_DWR) begin
      plain[pos[AW-1:0]] <= st_q;
    end
    pl_q <= plain[k[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      out_valid <= 1'b0;
      len       <= '0;
      ovf       <= 1'b0;
      nr        <= RW'(1);
      dec       <= rfc_pkg::MODE_ENCRYPT;
      rail      <= '0;
      pos       <= '0;
      ph        <= 1'b0;
      k         <= '0;
    end else begin
      // in the output state the beat register is handled below
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (q_pop && q_head.eom) begin
            len   <= q_head.len;
            ovf   <= q_head.ovf;
            nr    <= nr_sat;
            dec   <= mode;
            rail  <= '0;
            pos   <= '0;
            ph    <= 1'b0;
            k     <= '0;
            state <= (mode == rfc_pkg::MODE_DECRYPT) ? S_DRD : S_RD;
          end
        end
        S_DRD: begin
          state <= S_DWR;
        end
        S_DWR: begin
          rail <= rail_next;
          pos  <= pos_next;
          ph   <= ph_next;
          if (last_k) begin
            k     <= '0;
            state <= S_RD;
          end else begin
            k     <= k + 1'b1;
            state <= S_DRD;
          end
        end
        S_RD: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid         <= 1'b1;
            out_data.out_byte <= dec ? pl_q : st_q;
            out_data.last_out <= last_k;
            out_data.overflow <= ovf;
            k                 <= k + 1'b1;
            if (!dec) begin
              rail <= rail_next;
              pos  <= pos_next;
              ph   <= ph_next;
            end
            state <= last_k ? S_LOAD : S_RD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule
